FILE: rtl/core/sbms_pkg.sv
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants of the sparse bit matrix store.
// ----------------------------------------------------------------------------
package sbms_pkg;

  localparam int MAX_PATCHES    = 4096;
  localparam int ROW_POOL_DEPTH = 65536;

  localparam int IDX_W   = $clog2(MAX_PATCHES);
  localparam int PC_W    = IDX_W + 1;
  localparam int POOL_AW = $clog2(ROW_POOL_DEPTH);
  localparam int FILL_W  = POOL_AW + 1;
  localparam int CHUNK_W = 9;
  localparam int ROWS_W  = 10;
  localparam int STAT_W  = 3;

  localparam logic [ROWS_W-1:0] NONE_SEEN = '1;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_SET   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DIAG  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd4;
  localparam logic [STAT_W-1:0] ST_ORDER = 3'd5;

  typedef struct packed {
    logic [CHUNK_W-1:0] offset;
    logic [7:0]         bits;
  } row_t;

  typedef struct packed {
    logic               en;
    logic [POOL_AW-1:0] addr;
    row_t               data;
  } pool_wr_t;

  typedef struct packed {
    logic [POOL_AW-1:0] start;
    logic [ROWS_W-1:0]  rows;
  } col_entry_t;

endpackage

FILE: rtl/core/sparse_bit_matrix_store_core.sv
// ----------------------------------------------------------------------------
// sparse_bit_matrix_store_core
// Column-wise sparse symmetric bit matrix with binary-search lookup.
// A build beat, or a query that needs no search, passes through the EVAL state and
// then strobes done, and busy drops in that strobe cycle.
// A searching query passes through the ISSUE and CMP states once per search step,
// with a final ISSUE when the byte is missing: at most 10 steps for a 512-row column.
// The receiver cannot stall: done is high for exactly one cycle per beat.
// After reset the column table is cleared entry by entry with busy high.
// ----------------------------------------------------------------------------
module sparse_bit_matrix_store_core
  import sbms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [PC_W-1:0]    cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [IDX_W-1:0]   index_a,
  input  logic [IDX_W-1:0]   index_b,
  input  logic [CHUNK_W-1:0] chunk,
  input  logic [7:0]         mask,
  input  logic               last_chunk,
  output logic               done,
  output logic [STAT_W-1:0]  status,
  output logic               visible,
  output logic [ROWS_W-1:0]  rows_in_column
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]         state;
  logic [PC_W-1:0]    patch_count;
  logic [IDX_W-1:0]   clr_cnt;
  logic [FILL_W-1:0]  pool_fill;
  logic               building;
  logic [IDX_W-1:0]   build_column;
  logic [ROWS_W-1:0]  last_seen;

  logic               op_q;
  logic [IDX_W-1:0]   x_q;
  logic [IDX_W-1:0]   y_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [7:0]         mask_q;
  logic               last_q;
  logic [ROWS_W-1:0]  lo;
  logic [ROWS_W-1:0]  hi;
  logic [ROWS_W-1:0]  mid_q;
  logic [ROWS_W-1:0]  rows_q;
  logic [POOL_AW-1:0] base;

  col_entry_t col_mem [MAX_PATCHES];
  col_entry_t col_q;
  col_entry_t col_wdata;
  logic       col_we;
  logic [IDX_W-1:0] col_waddr;
  logic [IDX_W-1:0] col_raddr;

  logic accept;
  logic [IDX_W-1:0] in_min;
  logic [IDX_W-1:0] in_max;

  logic [7:0]  bits;
  logic [7:0]  below;
  logic        in_x;
  logic        in_y;
  logic        err_order;
  logic        err_set;
  logic        err_diag;
  logic        err_full;
  logic        build_ok;
  logic        has_bits;
  logic [ROWS_W-1:0] rows_new;

  logic [ROWS_W-1:0] mid;
  logic [FILL_W-1:0] probe;
  row_t              pool_rd;
  pool_wr_t          pool_wr;
  logic [CHUNK_W-1:0] want;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_min = (index_a < index_b) ? index_a : index_b;
  assign in_max = (index_a < index_b) ? index_b : index_a;
  assign col_raddr = (opcode == OP_QUERY) ? in_min : index_a;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      bits[k]  = mask_q[k] && ({1'b0, chunk_q, 3'(k)} < patch_count);
      below[k] = ({chunk_q, 3'(k)} < x_q);
    end
  end

  assign in_x      = ({1'b0, x_q} < patch_count);
  assign in_y      = ({1'b0, y_q} < patch_count);
  assign has_bits  = (bits != 8'd0);
  assign err_order = building && ((x_q != build_column) ||
                     ((last_seen != NONE_SEEN) && ({1'b0, chunk_q} <= last_seen)));
  assign err_set   = !building && (col_q.rows != '0);
  assign err_diag  = ((bits & below) != 8'd0);
  assign err_full  = has_bits && pool_fill[POOL_AW];
  assign build_ok  = in_x && !err_order && !err_set && !err_diag && !err_full;
  assign rows_new  = col_q.rows + ROWS_W'(has_bits);

  assign mid   = lo + ((hi - lo) >> 1);
  assign probe = {1'b0, base} + FILL_W'(mid);
  assign want  = y_q[IDX_W-1:3];

  always_comb begin
    pool_wr.en   = (state == S_EVAL) && (op_q == OP_BUILD) && build_ok && has_bits;
    pool_wr.addr = pool_fill[POOL_AW-1:0];
    pool_wr.data = '{offset: chunk_q, bits: bits};
  end

  always_comb begin
    col_we    = 1'b0;
    col_waddr = x_q;
    col_wdata = '{start: col_q.start, rows: rows_new};
    if (state == S_CLEAR) begin
      col_we    = 1'b1;
      col_waddr = clr_cnt;
      col_wdata = '0;
    end else if (pool_wr.en) begin
      col_we = 1'b1;
      if (col_q.rows == '0) begin
        col_wdata.start = pool_fill[POOL_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_q <= col_mem[col_raddr];
  end

  sbms_row_pool u_pool (
    .clk     (clk),
    .wr      (pool_wr),
    .rd_addr (probe[POOL_AW-1:0]),
    .rd_data (pool_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      patch_count  <= PC_W'(MAX_PATCHES);
      clr_cnt      <= '0;
      pool_fill    <= '0;
      building     <= 1'b0;
      build_column <= '0;
      last_seen    <= NONE_SEEN;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        patch_count <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(MAX_PATCHES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= opcode;
            x_q     <= col_raddr;
            y_q     <= in_max;
            chunk_q <= chunk;
            mask_q  <= mask;
            last_q  <= last_chunk;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          rows_q <= col_q.rows;
          if (op_q == OP_QUERY) begin
            if (x_q == y_q) begin
              done           <= 1'b1;
              status         <= ST_OK;
              visible        <= 1'b1;
              rows_in_column <= in_x ? col_q.rows : '0;
              state          <= S_IDLE;
            end else if (!in_y) begin
              done           <= 1'b1;
              status         <= ST_RANGE;
              visible        <= 1'b0;
              rows_in_column <= '0;
              state          <= S_IDLE;
            end else begin
              lo    <= '0;
              hi    <= col_q.rows;
              base  <= col_q.start;
              state <= S_ISSUE;
            end
          end else begin
            done    <= 1'b1;
            visible <= 1'b0;
            state   <= S_IDLE;
            if (!in_x) begin
              status         <= ST_RANGE;
              rows_in_column <= '0;
            end else if (!build_ok) begin
              rows_in_column <= col_q.rows;
              if (err_order) begin
                status <= ST_ORDER;
              end else if (err_set) begin
                status <= ST_SET;
              end else if (err_diag) begin
                status <= ST_DIAG;
              end else begin
                status <= ST_FULL;
              end
            end else begin
              status         <= ST_OK;
              rows_in_column <= rows_new;
              if (has_bits) begin
                pool_fill <= pool_fill + 1'b1;
              end
              if (last_q) begin
                building  <= 1'b0;
                last_seen <= NONE_SEEN;
              end else begin
                building     <= 1'b1;
                build_column <= x_q;
                last_seen    <= {1'b0, chunk_q};
              end
            end
          end
        end
        S_ISSUE: begin
          if ((lo < hi) && !probe[POOL_AW]) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            done           <= 1'b1;
            status         <= ST_OK;
            visible        <= 1'b0;
            rows_in_column <= rows_q;
            state          <= S_IDLE;
          end
        end
        S_CMP: begin
          if (pool_rd.offset < want) begin
            lo    <= mid_q + 1'b1;
            state <= S_ISSUE;
          end else if (pool_rd.offset > want) begin
            hi    <= mid_q;
            state <= S_ISSUE;
          end else begin
            done           <= 1'b1;
            status         <= ST_OK;
            visible        <= pool_rd.bits[y_q[2:0]];
            rows_in_column <= rows_q;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/sbms_row_pool.sv
// ----------------------------------------------------------------------------
// sbms_row_pool
// Shared row pool: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbms_row_pool
  import sbms_pkg::*;
(
  input  logic               clk,
  input  pool_wr_t           wr,
  input  logic [POOL_AW-1:0] rd_addr,
  output row_t               rd_data
);

  row_t mem [ROW_POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the sparse bit matrix store core.
// Column builds, bit queries and random noise are queued by the stimulus
// process and driven one beat at a time. Every accepted beat is run
// through a behavioral copy of the store. Each result strobe is then
// checked field by field against the oldest predicted result. The run
// steps through several patch counts and sender idle rates.
// ----------------------------------------------------------------------------
module tb;
  import sbms_pkg::*;

  typedef struct packed {
    logic               hold;
    logic               op;
    logic [IDX_W-1:0]   a;
    logic [IDX_W-1:0]   b;
    logic [CHUNK_W-1:0] chunk;
    logic [7:0]         mask;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              vis;
    logic [ROWS_W-1:0] rows;
  } lookup_res_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [PC_W-1:0]    cfg_data = '0;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode = OP_BUILD;
  logic [IDX_W-1:0]   index_a = '0;
  logic [IDX_W-1:0]   index_b = '0;
  logic [CHUNK_W-1:0] chunk = '0;
  logic [7:0]         mask = '0;
  logic               last_chunk = 1'b0;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic               visible;
  logic [ROWS_W-1:0]  rows_in_column;

  sparse_bit_matrix_store_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .opcode(opcode), .index_a(index_a),
    .index_b(index_b), .chunk(chunk), .mask(mask), .last_chunk(last_chunk),
    .done(done), .status(status), .visible(visible),
    .rows_in_column(rows_in_column)
  );

  beat_t       pending_beats[$];
  lookup_res_t expected_results[$];
  beat_t       cur_beat;
  bit          beat_taken = 1'b0;
  int          idle_pct = 0;
  int          errors = 0;
  int          beats_made = 0;

  // Behavioral copy of the store.
  logic [PC_W-1:0]    pc_m;
  logic [FILL_W-1:0]  col_base  [MAX_PATCHES];
  logic [ROWS_W-1:0]  col_count [MAX_PATCHES];
  logic [CHUNK_W-1:0] pool_off  [ROW_POOL_DEPTH];
  logic [7:0]         pool_bits [ROW_POOL_DEPTH];
  logic [FILL_W-1:0]  pool_used;
  logic               bld_open;
  logic [IDX_W-1:0]   bld_col;
  logic [ROWS_W-1:0]  bld_last;

  // Stimulus bookkeeping.
  bit claimed [MAX_PATCHES];
  int built_cols[$];
  int gen_limit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL sparse_bit_matrix_store_core");
    $finish;
  end

  function automatic bit idx_ok(int i);
    return i < int'(pc_m) && i < MAX_PATCHES;
  endfunction

  function automatic logic search_bit(int c, int r);
    int lo, hi, mid, p, want;
    lo = 0;
    hi = int'(col_count[IDX_W'(c)]);
    want = r >> 3;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      p = int'(col_base[IDX_W'(c)]) + mid;
      if (p >= ROW_POOL_DEPTH) return 1'b0;
      if (int'(pool_off[POOL_AW'(p)]) < want) lo = mid + 1;
      else if (int'(pool_off[POOL_AW'(p)]) > want) hi = mid;
      else return pool_bits[POOL_AW'(p)][3'(r)];
    end
    return 1'b0;
  endfunction

  task automatic predict_lookup(beat_t t);
    int x, y, base_row;
    logic [7:0] bits;
    bit below;
    lookup_res_t r;
    r.status = ST_OK;
    r.vis = 1'b0;
    r.rows = '0;
    if (t.op == OP_QUERY) begin
      x = int'((t.a < t.b) ? t.a : t.b);
      y = int'((t.a < t.b) ? t.b : t.a);
      if (x == y) begin
        r.vis = 1'b1;
        if (idx_ok(x)) r.rows = col_count[IDX_W'(x)];
      end else if (!idx_ok(y)) begin
        r.status = ST_RANGE;
      end else begin
        r.vis = search_bit(x, y);
        r.rows = col_count[IDX_W'(x)];
      end
    end else if (!idx_ok(int'(t.a))) begin
      r.status = ST_RANGE;
    end else begin
      base_row = int'(t.chunk) * 8;
      bits = '0;
      below = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if (t.mask[3'(k)] && base_row + k < int'(pc_m)) bits[3'(k)] = 1'b1;
        if (bits[3'(k)] && base_row + k < int'(t.a)) below = 1'b1;
      end
      r.rows = col_count[t.a];
      if (bld_open && (t.a != bld_col ||
                       (bld_last != NONE_SEEN && {1'b0, t.chunk} <= bld_last))) begin
        r.status = ST_ORDER;
      end else if (!bld_open && col_count[t.a] != 0) begin
        r.status = ST_SET;
      end else if (below) begin
        r.status = ST_DIAG;
      end else if (bits != 0 && int'(pool_used) >= ROW_POOL_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (!bld_open) begin
          bld_open = 1'b1;
          bld_col = t.a;
        end
        if (bits != 0) begin
          if (col_count[t.a] == 0) col_base[t.a] = pool_used;
          pool_off[pool_used[POOL_AW-1:0]] = t.chunk;
          pool_bits[pool_used[POOL_AW-1:0]] = bits;
          pool_used = pool_used + 1'b1;
          col_count[t.a] = col_count[t.a] + 1'b1;
        end
        bld_last = {1'b0, t.chunk};
        if (t.last) begin
          bld_open = 1'b0;
          bld_last = NONE_SEEN;
        end
        r.rows = col_count[t.a];
      end
    end
    expected_results.push_back(r);
  endtask

  // Driver: presents one queued beat at a time and holds it until taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
    end else begin
      beat_taken = 1'b0;
      if (pending_beats.size() > 0 && pending_beats[0].hold) begin
        if (expected_results.size() == 0) void'(pending_beats.pop_front());
        start <= 1'b0;
      end else if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_beat = pending_beats.pop_front();
        start <= 1'b1;
        opcode <= cur_beat.op;
        index_a <= cur_beat.a;
        index_b <= cur_beat.b;
        chunk <= cur_beat.chunk;
        mask <= cur_beat.mask;
        last_chunk <= cur_beat.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result strobes, then records the beat taken at this edge.
  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result strobe at %0t", $time);
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status || visible !== e.vis || rows_in_column !== e.rows) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: status %0d/%0d visible %0d/%0d rows %0d/%0d",
                       $time, e.status, status, e.vis, visible, e.rows, rows_in_column);
          end
        end
      end
      if (start && !busy) begin
        predict_lookup(cur_beat);
        beat_taken = 1'b1;
      end
    end
  end

  task automatic add_beat(logic op, int a, int b, int ch, int m, logic last);
    beat_t t;
    t.hold = 1'b0;
    t.op = op;
    t.a = IDX_W'(a);
    t.b = IDX_W'(b);
    t.chunk = CHUNK_W'(ch);
    t.mask = 8'(m);
    t.last = last;
    pending_beats.push_back(t);
    beats_made++;
  endtask

  task automatic add_hold();
    beat_t t;
    t = '0;
    t.hold = 1'b1;
    pending_beats.push_back(t);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic set_patch_count(int v, int idle);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= PC_W'(v);
    pc_m = PC_W'(v);
    gen_limit = (v < MAX_PATCHES) ? v : MAX_PATCHES;
    @(negedge clk);
    cfg_we <= 1'b0;
    idle_pct = idle;
  endtask

  function automatic int pick_fresh();
    int c;
    if (gen_limit == 0) return -1;
    for (int i = 0; i < 40; i++) begin
      c = $urandom_range(gen_limit - 1);
      if (!claimed[IDX_W'(c)]) return c;
    end
    return -1;
  endfunction

  task automatic query_col(int c);
    int y;
    if ($urandom_range(19) == 0) y = c;
    else if ($urandom_range(3) == 0) y = $urandom_range(4095, c);
    else y = (c + $urandom_range(90) > 4095) ? 4095 : c + $urandom_range(90);
    if ($urandom_range(1)) add_beat(OP_QUERY, c, y, $urandom_range(511),
                                    $urandom_range(255), 1'($urandom_range(1)));
    else add_beat(OP_QUERY, y, c, $urandom_range(511), $urandom_range(255),
                  1'($urandom_range(1)));
  endtask

  task automatic add_noise();
    logic op, last;
    int a, ch;
    op = 1'($urandom_range(1));
    last = 1'($urandom_range(1));
    a = $urandom_range(4095);
    ch = $urandom_range(511);
    if (op == OP_BUILD && !last && ch == 511) ch = 510;
    add_beat(op, a, $urandom_range(4095), ch, $urandom_range(255), last);
    if (op == OP_BUILD) begin
      claimed[IDX_W'(a)] = 1'b1;
      if (!last) add_beat(OP_BUILD, a, $urandom_range(4095), 511, 0, 1'b1);
    end
  endtask

  task automatic build_column(int c, int max_chunks);
    int n, ch, nxt, m, other;
    bit is_last;
    claimed[IDX_W'(c)] = 1'b1;
    built_cols.push_back(c);
    if (c >= 8 && $urandom_range(3) == 0)
      add_beat(OP_BUILD, c, $urandom_range(4095), $urandom_range(c / 8 - 1),
               $urandom_range(255, 1), 1'($urandom_range(1)));
    n = $urandom_range(max_chunks, 1);
    ch = c / 8;
    for (int i = 0; i < n; i++) begin
      nxt = ch + (($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1));
      is_last = (i == n - 1) || nxt > 511;
      if (i == 0) m = ($urandom_range(255, 1) << (c % 8)) & 255;
      else m = ($urandom_range(4) == 0) ? 0 : $urandom_range(255, 1);
      if (i > 0) begin
        if ($urandom_range(11) == 0)
          add_beat(OP_BUILD, c, $urandom_range(4095), ch - $urandom_range(1),
                   $urandom_range(255), 1'($urandom_range(1)));
        if ($urandom_range(19) == 0) begin
          other = (c + $urandom_range(4095, 1)) % 4096;
          add_beat(OP_BUILD, other, $urandom_range(4095), $urandom_range(511),
                   $urandom_range(255), 1'($urandom_range(1)));
        end
        if ($urandom_range(19) == 0) query_col(c);
      end
      add_beat(OP_BUILD, c, $urandom_range(4095), ch, m, is_last);
      if (is_last) break;
      ch = nxt;
    end
    repeat ($urandom_range(6, 2)) query_col(c);
  endtask

  task automatic run_random(int target);
    int goal, sel, c;
    goal = beats_made + target;
    while (beats_made < goal) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        c = pick_fresh();
        if (c >= 0) build_column(c, ($urandom_range(9) == 0) ? 40 : 8);
        else add_noise();
      end else if (sel < 75) begin
        if (built_cols.size() > 0) query_col(built_cols[$urandom_range(built_cols.size() - 1)]);
        else add_noise();
      end else if (sel < 82) begin
        if (built_cols.size() > 0)
          add_beat(OP_BUILD, built_cols[$urandom_range(built_cols.size() - 1)],
                   $urandom_range(4095), $urandom_range(511), $urandom_range(255), 1'b1);
        else add_noise();
      end else if (sel < 96) begin
        add_noise();
      end else begin
        add_hold();
      end
    end
  endtask

  initial begin
    pc_m = 4096;
    gen_limit = MAX_PATCHES;
    pool_used = '0;
    bld_open = 1'b0;
    bld_col = '0;
    bld_last = NONE_SEEN;
    for (int i = 0; i < MAX_PATCHES; i++) begin
      col_count[IDX_W'(i)] = '0;
      claimed[IDX_W'(i)] = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);

    // Full size: corners, the order, set and diagonal errors, then one full column.
    set_patch_count(4096, 0);
    add_beat(OP_QUERY, 0, 0, 0, 0, 1'b0);
    add_beat(OP_QUERY, 4095, 4095, 511, 255, 1'b1);
    add_beat(OP_QUERY, 4095, 0, 0, 0, 1'b0);
    add_beat(OP_BUILD, 4095, 0, 0, 8'hff, 1'b0);
    add_beat(OP_BUILD, 4095, 4095, 511, 8'h80, 1'b1);
    add_beat(OP_QUERY, 4095, 4095, 0, 0, 1'b0);
    add_beat(OP_BUILD, 4095, 0, 511, 8'h80, 1'b1);
    add_beat(OP_BUILD, 10, 0, 1, 8'hff, 1'b0);
    add_beat(OP_BUILD, 10, 0, 1, 8'hfc, 1'b0);
    add_beat(OP_BUILD, 11, 0, 3, 8'hff, 1'b0);
    add_beat(OP_BUILD, 10, 0, 1, 8'h01, 1'b1);
    add_beat(OP_QUERY, 10, 12, 0, 0, 1'b0);
    add_beat(OP_BUILD, 10, 0, 2, 8'h00, 1'b0);
    add_beat(OP_BUILD, 10, 0, 5, 8'ha5, 1'b1);
    add_beat(OP_QUERY, 45, 10, 0, 0, 1'b0);
    add_beat(OP_QUERY, 10, 17, 0, 0, 1'b0);
    add_beat(OP_BUILD, 20, 0, 0, 8'h00, 1'b1);
    add_beat(OP_BUILD, 20, 0, 3, 8'hff, 1'b1);
    foreach (built_cols[i]) claimed[IDX_W'(built_cols[i])] = 1'b1;
    claimed[4095] = 1'b1;
    claimed[10] = 1'b1;
    claimed[11] = 1'b1;
    claimed[20] = 1'b1;
    built_cols.push_back(4095);
    built_cols.push_back(10);
    built_cols.push_back(20);
    claimed[0] = 1'b1;
    built_cols.push_back(0);
    for (int ch = 0; ch < 512; ch++)
      add_beat(OP_BUILD, 0, $urandom_range(4095), ch, $urandom_range(255, 1), ch == 511);
    run_random(200);

    // Small matrix: index range and bits past the last row.
    set_patch_count(13, 78);
    add_beat(OP_QUERY, 5, 13, 0, 0, 1'b0);
    add_beat(OP_QUERY, 13, 13, 0, 0, 1'b0);
    add_beat(OP_BUILD, 13, 0, 1, 8'hff, 1'b1);
    add_beat(OP_QUERY, 12, 12, 0, 0, 1'b0);
    add_beat(OP_BUILD, 8, 0, 1, 8'hff, 1'b1);
    add_beat(OP_BUILD, 9, 0, 2, 8'hff, 1'b1);
    add_beat(OP_QUERY, 8, 12, 0, 0, 1'b0);
    add_beat(OP_QUERY, 8, 13, 0, 0, 1'b0);
    add_beat(OP_QUERY, 4095, 0, 0, 0, 1'b0);
    claimed[8] = 1'b1;
    claimed[9] = 1'b1;
    built_cols.push_back(8);
    run_random(110);

    set_patch_count(8191, 20);
    run_random(250);
    set_patch_count(0, 0);
    run_random(40);
    set_patch_count(1, 78);
    run_random(40);
    set_patch_count(4097, 20);
    run_random(100);
    set_patch_count(1000, 0);
    run_random(150);

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sparse_bit_matrix_store_core");
    end else begin
      $display("FAIL sparse_bit_matrix_store_core");
    end
    $finish;
  end

endmodule

FILE: sparse_bit_matrix_store_core.f
rtl/core/sbms_pkg.sv
rtl/core/sbms_row_pool.sv
rtl/core/sparse_bit_matrix_store_core.sv
verif/tb.sv
